[sv/running_numeric_integrator_unit_defines.svh]
// ---------------------------------------------------------------------------
// Running numeric integrator: assertion macros
// Shared concurrent-assertion shorthands for the checker.
// ---------------------------------------------------------------------------
`ifndef RUNNING_NUMERIC_INTEGRATOR_UNIT_DEFINES_SVH
`define RUNNING_NUMERIC_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RNI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define RNI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rni_pkg.sv]
// ---------------------------------------------------------------------------
// rni_pkg
// Widths, codes and shared types of the running numeric integrator.
// ---------------------------------------------------------------------------
package rni_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 32;  // signed Q16.16 sample
  localparam int unsigned ACCUM_W    = 48;  // signed Q32.16 running sum
  localparam int unsigned STEP_W     = 32;  // unsigned Q16.16 spacing
  localparam int unsigned STEP_LO_W  = 16;  // fraction bits of Q16.16
  localparam int unsigned START_W    = 32;  // signed Q16.16 start abscissa
  localparam int unsigned XPOS_W     = 48;  // signed Q32.16 abscissa
  localparam int unsigned RULE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Datapath widths: weighted sample sum, partial products, scaled term
  localparam int unsigned SUM_W  = SAMPLE_W + 3;               // y0 + 4*y1 + y2
  localparam int unsigned PP_W   = SUM_W + STEP_W - STEP_LO_W;  // |s| * d[31:16]
  localparam int unsigned PL_W   = SUM_W + STEP_LO_W + 1;       // |s| * d[15:0] + bias
  localparam int unsigned XQ_W   = PP_W + 1;                    // rounded numerator
  localparam int unsigned ACC_EXT_W = XQ_W + 2;                 // unclamped sum

  // Divide-by-three in two digit steps with a reciprocal multiply
  localparam int unsigned DIV_CW   = (XQ_W + 1) / 2;
  localparam int unsigned DIV_HI_W = XQ_W - DIV_CW;
  localparam int unsigned DIV_V_W  = DIV_CW + 2;
  localparam int unsigned RECIP_SH = DIV_CW + 4;
  localparam int unsigned RECIP_W  = RECIP_SH - 1;
  localparam int unsigned PROD_W   = DIV_V_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);

  // Saturation bounds
  localparam logic [ACCUM_W-1:0] ACC_MAX = {1'b0, {(ACCUM_W-1){1'b1}}};
  localparam logic [ACCUM_W-1:0] ACC_MIN = {1'b1, {(ACCUM_W-1){1'b0}}};

  // Command queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Output stream packing
  localparam int unsigned OUT_DATA_W = XPOS_W + ACCUM_W;
  localparam int unsigned OUT_USER_W = 2;

  // Integration rules; codes above SIMP behave as TRAP
  typedef enum logic [RULE_W-1:0] {
    RULE_AVG   = 3'd0,
    RULE_RIGHT = 3'd1,
    RULE_LEFT  = 3'd2,
    RULE_TRAP  = 3'd3,
    RULE_SIMP  = 3'd4
  } rule_e;

  // Register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE  = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_START = 2'd2
  } cfg_idx_e;

  // Divisor of a contribution; the code equals the divisor
  typedef enum logic [1:0] {
    KIND_ONE   = 2'd1,
    KIND_HALF  = 2'd2,
    KIND_THIRD = 2'd3
  } kind_e;

  // Reset value of the step config register
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1) << STEP_LO_W;

  // Classified request handed from front to back
  typedef struct packed {
    logic                       first;     // series start: clear and emit origin
    logic                       fin;       // last sample of the series
    logic                       term;      // a contribution is added and emitted
    logic                       step_add;  // term abscissa is one step ahead
    kind_e                      kind;
    logic signed [SUM_W-1:0]    sum;       // weighted sample sum
    logic [STEP_W-1:0]          step;
    logic [XPOS_W-1:0]          xpos;      // abscissa of the current sample
  } cmd_t;

  // Result shown on the output stream
  typedef struct packed {
    logic               sat;
    logic               send;
    logic               last;
    logic [ACCUM_W-1:0] integral;
    logic [XPOS_W-1:0]  xpos;
  } res_t;

endpackage

[sv/rni_fifo.sv]
// ---------------------------------------------------------------------------
// rni_fifo
// Short request queue between the classifying front and the arithmetic back.
// ---------------------------------------------------------------------------
module rni_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rni_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rni_pkg::cmd_t cmd_o
);

  rni_pkg::cmd_t                  mem_q [rni_pkg::FIFO_DEPTH];
  logic [rni_pkg::FIFO_AW-1:0]    wptr_q, rptr_q;
  logic [rni_pkg::FIFO_AW:0]      cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (rni_pkg::FIFO_AW + 1)'(rni_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

[sv/rni_front.sv]
// ---------------------------------------------------------------------------
// rni_front
// Accepts samples, tracks series position and history, picks the rule's
// weighted sample sum and divisor, and queues a request for the back end.
// ---------------------------------------------------------------------------
module rni_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rni_pkg::SAMPLE_W-1:0]   in_sample_i,
  input  logic                           in_final_i,
  input  logic [rni_pkg::RULE_W-1:0]     rule_i,
  input  logic [rni_pkg::STEP_W-1:0]     step_i,
  input  logic [rni_pkg::START_W-1:0]    start_i,
  input  logic                           full_i,
  output logic                           push_o,
  output rni_pkg::cmd_t                  cmd_o
);

  logic                                 started_q;
  logic                                 par_q, par_d;
  logic [rni_pkg::SAMPLE_W-1:0]         prev_q, pprev_q;
  logic [rni_pkg::XPOS_W-1:0]           cur_q, cur_d;
  logic                                 take, first;
  logic signed [rni_pkg::SUM_W-1:0]     y_ext, p_ext, b_ext;
  logic                                 term;
  logic                                 step_add;
  rni_pkg::kind_e                       kind;
  logic signed [rni_pkg::SUM_W-1:0]     sum;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign first      = !started_q;

  assign y_ext = {{(rni_pkg::SUM_W - rni_pkg::SAMPLE_W){in_sample_i[rni_pkg::SAMPLE_W-1]}},
                  in_sample_i};
  assign p_ext = {{(rni_pkg::SUM_W - rni_pkg::SAMPLE_W){prev_q[rni_pkg::SAMPLE_W-1]}},
                  prev_q};
  assign b_ext = {{(rni_pkg::SUM_W - rni_pkg::SAMPLE_W){pprev_q[rni_pkg::SAMPLE_W-1]}},
                  pprev_q};

  // Abscissa and parity of this sample
  always_comb begin
    if (first) begin
      cur_d = {{(rni_pkg::XPOS_W - rni_pkg::START_W){start_i[rni_pkg::START_W-1]}}, start_i};
      par_d = 1'b0;
    end else begin
      cur_d = cur_q + {{(rni_pkg::XPOS_W - rni_pkg::STEP_W){1'b0}}, step_i};
      par_d = !par_q;
    end
  end

  // Rule decode
  always_comb begin
    term     = 1'b0;
    step_add = 1'b0;
    kind     = rni_pkg::KIND_ONE;
    sum      = y_ext;
    unique case (rni_pkg::rule_e'(rule_i))
      rni_pkg::RULE_AVG: begin
        term     = 1'b1;
        step_add = 1'b1;
        kind     = (first || in_final_i) ? rni_pkg::KIND_HALF : rni_pkg::KIND_ONE;
      end
      rni_pkg::RULE_RIGHT: begin
        term = !first;
      end
      rni_pkg::RULE_LEFT: begin
        term = !first;
        sum  = p_ext;
      end
      rni_pkg::RULE_SIMP: begin
        if (!par_d) begin
          // even index closes a pair
          term = !first;
          kind = rni_pkg::KIND_THIRD;
          sum  = b_ext + (p_ext <<< 2) + y_ext;
        end else begin
          // odd final index: trapezoid tail
          term = !first && in_final_i;
          kind = rni_pkg::KIND_HALF;
          sum  = p_ext + y_ext;
        end
      end
      default: begin
        term = !first;
        kind = rni_pkg::KIND_HALF;
        sum  = p_ext + y_ext;
      end
    endcase
  end

  // Request to the queue
  assign push_o         = take && (first || term);
  assign cmd_o.first    = first;
  assign cmd_o.fin      = in_final_i;
  assign cmd_o.term     = term;
  assign cmd_o.step_add = step_add;
  assign cmd_o.kind     = kind;
  assign cmd_o.sum      = sum;
  assign cmd_o.step     = step_i;
  assign cmd_o.xpos     = cur_d;

  // Series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      par_q     <= 1'b0;
      prev_q    <= '0;
      pprev_q   <= '0;
      cur_q     <= '0;
    end else if (take) begin
      started_q <= !in_final_i;
      par_q     <= par_d;
      prev_q    <= in_sample_i;
      pprev_q   <= prev_q;
      cur_q     <= cur_d;
    end
  end

endmodule

[sv/rni_back.sv]
// ---------------------------------------------------------------------------
// rni_back
// Scales each queued sum by the step with rounding, divides by the rule's
// divisor, accumulates with saturation and presents up to two results.
// ---------------------------------------------------------------------------
module rni_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rni_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rni_pkg::res_t out_o
);

  typedef struct packed {
    logic                         first;
    logic                         fin;
    logic                         term;
    logic                         neg;
    rni_pkg::kind_e               kind;
    logic [rni_pkg::XPOS_W-1:0]   x_org;
    logic [rni_pkg::XPOS_W-1:0]   x_term;
  } meta_t;

  // Pipeline registers
  logic                             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  meta_t                            s1_meta_q, s2_meta_q, s3_meta_q, s4_meta_q, s5_meta_q;
  meta_t                            s1_meta_d;
  logic [rni_pkg::SUM_W-1:0]        s1_mag_q, s1_mag_d;
  logic [rni_pkg::STEP_W-1:0]       s1_step_q;
  logic [rni_pkg::PP_W-1:0]         s2_phi_q, s2_phi_d;
  logic [rni_pkg::PL_W-1:0]         s2_plo_q, s2_plo_d;
  logic [rni_pkg::XQ_W-1:0]         s3_xq_q, s3_xq_d;
  logic [rni_pkg::XQ_W-1:0]         s4_xq_q;
  logic [rni_pkg::DIV_HI_W-1:0]     s4_qhi_q, s4_qhi_d;
  logic [1:0]                       s4_rem_q;
  logic [rni_pkg::XQ_W-1:0]         s5_quo_q, s5_quo_d;

  // Divider step signals
  logic [rni_pkg::DIV_V_W-1:0]      vhi, rem_hi, vlo;
  logic [rni_pkg::PROD_W-1:0]       prod_hi, prod_lo;
  logic [rni_pkg::DIV_CW-1:0]       qlo;

  // Accumulator
  logic [rni_pkg::ACCUM_W-1:0]      acc_q, acc_d, base;
  logic                             clip_q, clip_d, cbase;
  logic signed [rni_pkg::ACC_EXT_W-1:0] ext_sum;
  logic [rni_pkg::ACC_EXT_W-rni_pkg::ACCUM_W:0] top_bits;
  logic                             fits;
  logic [rni_pkg::ACCUM_W-1:0]      clamped;

  // Output register
  logic                             out_valid_q, out_org_q, out_term_q, out_fin_q, out_sat_q;
  logic [rni_pkg::XPOS_W-1:0]       out_xo_q, out_xt_q;
  logic [rni_pkg::ACCUM_W-1:0]      out_sum_q;
  logic                             shown_last, fire, en;

  // Whole pipeline moves when the output register frees up
  assign shown_last = !out_org_q || !out_term_q;
  assign fire       = out_valid_q && out_ready_i;
  assign en         = !out_valid_q || (out_ready_i && shown_last);
  assign pop_o      = en && cmd_valid_i;

  // Stage 1: sign and magnitude, term abscissa
  always_comb begin
    s1_meta_d.first  = cmd_i.first;
    s1_meta_d.fin    = cmd_i.fin;
    s1_meta_d.term   = cmd_i.term;
    s1_meta_d.neg    = cmd_i.sum[rni_pkg::SUM_W-1];
    s1_meta_d.kind   = cmd_i.kind;
    s1_meta_d.x_org  = cmd_i.xpos;
    s1_meta_d.x_term = cmd_i.step_add
                       ? cmd_i.xpos + {{(rni_pkg::XPOS_W - rni_pkg::STEP_W){1'b0}}, cmd_i.step}
                       : cmd_i.xpos;
    s1_mag_d = s1_meta_d.neg ? (~cmd_i.sum + rni_pkg::SUM_W'(1)) : cmd_i.sum;
  end

  // Stage 2: partial products against the step halves, rounding bias folded in
  assign s2_phi_d = rni_pkg::PP_W'(s1_mag_q)
                  * rni_pkg::PP_W'(s1_step_q[rni_pkg::STEP_W-1:rni_pkg::STEP_LO_W]);
  assign s2_plo_d = rni_pkg::PL_W'(s1_mag_q)
                  * rni_pkg::PL_W'(s1_step_q[rni_pkg::STEP_LO_W-1:0])
                  + rni_pkg::PL_W'({s1_meta_q.kind, {(rni_pkg::STEP_LO_W-1){1'b0}}});

  // Stage 3: combine into the rounded numerator
  assign s3_xq_d = rni_pkg::XQ_W'(s2_phi_q)
                 + rni_pkg::XQ_W'(s2_plo_q[rni_pkg::PL_W-1:rni_pkg::STEP_LO_W]);

  // Stage 4: upper digit of the divide by three
  always_comb begin
    vhi      = rni_pkg::DIV_V_W'(s3_xq_q[rni_pkg::XQ_W-1:rni_pkg::DIV_CW]);
    prod_hi  = rni_pkg::PROD_W'(vhi) * rni_pkg::PROD_W'(rni_pkg::RECIP);
    s4_qhi_d = prod_hi[rni_pkg::RECIP_SH +: rni_pkg::DIV_HI_W];
    rem_hi   = vhi - rni_pkg::DIV_V_W'({s4_qhi_d, 1'b0}) - rni_pkg::DIV_V_W'(s4_qhi_d);
  end

  // Stage 5: lower digit, then pick the divisor's quotient
  always_comb begin
    vlo     = {s4_rem_q, s4_xq_q[rni_pkg::DIV_CW-1:0]};
    prod_lo = rni_pkg::PROD_W'(vlo) * rni_pkg::PROD_W'(rni_pkg::RECIP);
    qlo     = prod_lo[rni_pkg::RECIP_SH +: rni_pkg::DIV_CW];
    case (s4_meta_q.kind)
      rni_pkg::KIND_THIRD: s5_quo_d = {s4_qhi_q, qlo};
      rni_pkg::KIND_HALF:  s5_quo_d = s4_xq_q >> 1;
      default:             s5_quo_d = s4_xq_q;
    endcase
  end

  // Accumulate with saturation; a series start clears first
  always_comb begin
    base     = s5_meta_q.first ? '0 : acc_q;
    cbase    = s5_meta_q.first ? 1'b0 : clip_q;
    ext_sum  = {{(rni_pkg::ACC_EXT_W - rni_pkg::ACCUM_W){base[rni_pkg::ACCUM_W-1]}}, base};
    if (s5_meta_q.neg) begin
      ext_sum = ext_sum - rni_pkg::ACC_EXT_W'(s5_quo_q);
    end else begin
      ext_sum = ext_sum + rni_pkg::ACC_EXT_W'(s5_quo_q);
    end
    top_bits = ext_sum[rni_pkg::ACC_EXT_W-1:rni_pkg::ACCUM_W-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      clamped = ext_sum[rni_pkg::ACCUM_W-1:0];
    end else if (ext_sum[rni_pkg::ACC_EXT_W-1]) begin
      clamped = rni_pkg::ACC_MIN;
    end else begin
      clamped = rni_pkg::ACC_MAX;
    end
    acc_d  = s5_meta_q.term ? clamped : base;
    clip_d = cbase || (s5_meta_q.term && !fits);
  end

  // Stage valids and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= cmd_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      if (s5_v_q) begin
        acc_q  <= acc_d;
        clip_q <= clip_d;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q <= s1_meta_d;
      s1_mag_q  <= s1_mag_d;
      s1_step_q <= cmd_i.step;
      s2_meta_q <= s1_meta_q;
      s2_phi_q  <= s2_phi_d;
      s2_plo_q  <= s2_plo_d;
      s3_meta_q <= s2_meta_q;
      s3_xq_q   <= s3_xq_d;
      s4_meta_q <= s3_meta_q;
      s4_xq_q   <= s3_xq_q;
      s4_qhi_q  <= s4_qhi_d;
      s4_rem_q  <= rem_hi[1:0];
      s5_meta_q <= s4_meta_q;
      s5_quo_q  <= s5_quo_d;
    end
  end

  // Output register control: origin goes out ahead of the term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_org_q   <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_v_q;
      out_org_q   <= s5_v_q && s5_meta_q.first;
    end else if (fire) begin
      out_org_q   <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (en && s5_v_q) begin
      out_term_q <= s5_meta_q.term;
      out_fin_q  <= s5_meta_q.fin;
      out_xo_q   <= s5_meta_q.x_org;
      out_xt_q   <= s5_meta_q.x_term;
      out_sum_q  <= acc_d;
      out_sat_q  <= clip_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_o.xpos     = out_org_q ? out_xo_q : out_xt_q;
  assign out_o.integral = out_org_q ? '0 : out_sum_q;
  assign out_o.last     = shown_last;
  assign out_o.send     = shown_last && out_fin_q;
  assign out_o.sat      = !out_org_q && out_sat_q;

endmodule

[sv/running_numeric_integrator_unit.sv]
// ---------------------------------------------------------------------------
// running_numeric_integrator_unit
// Streaming cumulative integrator over uniformly spaced Q16.16 samples.
// ---------------------------------------------------------------------------
// Takes one sample per clock while the request queue has room and returns
// points of the running integral: the first sample of a series gives the
// origin (start_x, 0), and each later sample gives the new point under the
// rule chosen by register 0 (average rectangle, right, left, trapezoid,
// Simpson; Simpson reports every second sample plus a trapezoid tail).
// s_axis_tlast closes a series. A sample passes the request queue, the
// arithmetic pipeline, the add-and-clamp of the 48-bit accumulator and the
// output register; the sustained rate is one sample per cycle while
// m_axis_tready is high. The first sample of a series in average-rectangle
// mode gives two results and stalls the pipeline while the origin is shown;
// a four-entry request queue between the front and the arithmetic pipeline
// absorbs that and any output stall. Configuration takes effect on the next
// sample; start_x is read at each series start.
// ---------------------------------------------------------------------------
module running_numeric_integrator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [rni_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rni_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rni_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [31:0] sample
  input  logic                              s_axis_tlast,   // is_final
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rni_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [47:0] x_position,
                                                            // [95:48] integral_value
  output logic                              m_axis_tlast,   // run_last
  output logic [rni_pkg::OUT_USER_W-1:0]    m_axis_tuser    // [0] series_end,
                                                            // [1] saturated
);

  logic [rni_pkg::RULE_W-1:0]   rule_q;
  logic [rni_pkg::STEP_W-1:0]   step_q;
  logic [rni_pkg::START_W-1:0]  start_q;

  logic                         push, full, pop, empty;
  rni_pkg::cmd_t                cmd_wr, cmd_rd;
  rni_pkg::res_t                res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q  <= rni_pkg::RULE_TRAP;
      step_q  <= rni_pkg::STEP_RST;
      start_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rni_pkg::cfg_idx_e'(cfg_idx_i))
        rni_pkg::CFG_RULE:  rule_q  <= cfg_wdata_i[rni_pkg::RULE_W-1:0];
        rni_pkg::CFG_STEP:  step_q  <= cfg_wdata_i[rni_pkg::STEP_W-1:0];
        rni_pkg::CFG_START: start_q <= cfg_wdata_i[rni_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify incoming samples
  rni_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .in_final_i  (s_axis_tlast),
    .rule_i      (rule_q),
    .step_i      (step_q),
    .start_i     (start_q),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_wr)
  );

  // Request queue
  rni_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_wr),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_rd)
  );

  // Scale, divide, accumulate, emit
  rni_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (cmd_rd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Output packing
  assign m_axis_tdata = {res.integral, res.xpos};
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.sat, res.send};

endmodule

[sv/rni_checker.sv]
// ---------------------------------------------------------------------------
// rni_checker
// Port-level checks on the integrator's result stream, bound to the top.
// ---------------------------------------------------------------------------
`include "running_numeric_integrator_unit_defines.svh"

module rni_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rni_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic [rni_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  // Stalled result stays offered
  `RNI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid,
                   "result dropped while stalled")

  // Stalled result keeps its contents
  `RNI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser),
                   "result changed while stalled")

  // A result that is not the last of its sample is the origin point
  `RNI_ASSERT_NOW(a_origin_shape, clk_i, rst_ni,
                  m_axis_tvalid && !m_axis_tlast,
                  (m_axis_tdata[rni_pkg::OUT_DATA_W-1:rni_pkg::XPOS_W] == '0)
                    && (m_axis_tuser == '0),
                  "leading result is not a clean origin")

  // The second result of a pair follows right after the origin
  `RNI_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   m_axis_tvalid && m_axis_tlast,
                   "second result of a pair missing")

endmodule

bind running_numeric_integrator_unit rni_checker u_rni_checker (.*);
